/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_OPER = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_BADOP = 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_DIV0  = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] operand_value;
        logic [7:0]         token_char;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] result_value;
        logic               expression_done;
        logic [6:0]         stack_depth;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD2,
        S_OPS,
        S_MUL,
        S_MUL2,
        S_DIV,
        S_FIN,
        S_WB,
        S_OUT
    } t_state;

endpackage

/* rtl/pse_ram.sv */
// ----------------------------------------------------------------------------
// pse_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/postfix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Token-by-token RPN evaluator on a RAM-backed stack of signed fixed-point
// values.
// ----------------------------------------------------------------------------
// One token is taken at a time and answered with exactly one result. A push
// passes through S_WB and S_OUT, an end token through S_FIN, S_WB and S_OUT,
// and an operator reads both operands in S_RD2 and S_OPS first. Multiply
// then forms four 16x16 partial products, each issued in S_MUL and collected
// in S_MUL2, to keep the multiplier small; divide runs 48 restoring steps at
// Q16.16 in the one-bit-per-cycle divider. The stack lives in one synchronous
// RAM with registered read data. The result sits in an output register: the
// next token is taken once it is gone. Errors and end tokens empty the stack
// by clearing the pointer alone.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_BITS  = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pse_pkg::t_in     i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output pse_pkg::t_out    o_data
);
    import pse_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int VB  = VALUE_BITS;
    localparam int HB  = (VB + 1) / 2;        // half width for partial products
    localparam int PB  = 2 * VB;              // product width
    localparam int NB  = VB + FRAC_BITS;      // divide dividend width
    localparam int CW  = $clog2(NB + 1);

    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    logic [PW-1:0]        r_sp, n_sp;
    t_in                  r_tok, n_tok;
    logic signed [VB-1:0] r_first, n_first;
    logic signed [VB-1:0] r_val, n_val;
    logic [2:0]           r_stat, n_stat;
    logic                 r_neg, n_neg;
    logic [VB-1:0]        r_ma, n_ma;       // magnitude of second
    logic [VB-1:0]        r_mb, n_mb;       // magnitude of first
    logic [PB+1:0]        r_acc, n_acc;     // product accumulator
    logic [1:0]           r_pp, n_pp;       // partial product index
    logic [NB-1:0]        r_quo, n_quo;     // dividend shifts out, quotient in
    logic [VB:0]          r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_ovalid, n_ovalid;
    t_out                 r_out, n_out;

    // ---------------------------------------------------------------- RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VB-1:0] ram_wdata, ram_rdata;

    pse_ram #(.WIDTH(VB), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Saturate the 32-bit input operand to VALUE_BITS.
    function automatic logic signed [VB-1:0] sat_in(input logic signed [31:0] v);
        logic signed [64:0] w;
        w = 65'(v);
        if (w > 65'(VMAX)) return VMAX;
        if (w < 65'(VMIN)) return VMIN;
        return VB'(w);
    endfunction

    // Saturate a sign and magnitude to the value range.
    function automatic logic signed [VB-1:0] pack_mag(input logic neg,
                                                      input logic big,
                                                      input logic [VB-1:0] m);
        if (neg) begin
            if (big || m > {1'b1, {(VB-1){1'b0}}}) return VMIN;
            return VB'(-m);
        end
        if (big || m[VB-1]) return VMAX;
        return m;
    endfunction

    logic signed [VB:0]   sum_w;
    logic [HB-1:0]        pa, pb;
    logic [2*HB-1:0]      pprod;
    logic [VB:0]          rem_sh;
    logic [VB+1:0]        rem_try;
    logic [PB+1:0]        prod_sh;

    always_comb begin
        unique case (r_pp)
            2'd0: begin pa = HB'(r_ma);        pb = HB'(r_mb);        end
            2'd1: begin pa = HB'(r_ma);        pb = HB'(r_mb >> HB);  end
            2'd2: begin pa = HB'(r_ma >> HB);  pb = HB'(r_mb);        end
            default: begin pa = HB'(r_ma >> HB); pb = HB'(r_mb >> HB); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        pprod <= pa * pb;
    end

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_tok    = r_tok;
        n_first  = r_first;
        n_val    = r_val;
        n_stat   = r_stat;
        n_neg    = r_neg;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_acc    = r_acc;
        n_pp     = r_pp;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_sp);
        ram_wdata = r_val;
        ram_raddr = AW'(r_sp - PW'(1));
        o_ready   = 1'b0;
        sum_w     = '0;
        rem_sh    = '0;
        rem_try   = '0;
        prod_sh   = '0;

        // drop the result once it is transferred
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = !r_ovalid;
                n_tok   = i_data;
                n_stat  = ST_OK;
                n_val   = '0;
                // read top of stack (or stack[0] for end token)
                if (i_data.action == ACT_END) begin
                    ram_raddr = '0;
                end
                if (i_valid && o_ready) begin
                    unique case (i_data.action)
                        ACT_PUSH: begin
                            if (r_sp >= PW'(STACK_DEPTH)) begin
                                n_stat = ST_FULL;
                            end else begin
                                n_val = sat_in(i_data.operand_value);
                            end
                            n_state = S_WB;
                        end
                        ACT_OPER: begin
                            if (r_sp < PW'(2)) begin
                                n_stat  = ST_UNDER;
                                n_state = S_WB;
                            end else begin
                                n_state = S_RD2;
                            end
                        end
                        ACT_END: begin
                            if (r_sp == '0) n_stat = ST_UNDER;
                            else if (r_sp > PW'(1)) n_stat = ST_LEFT;
                            n_state = S_FIN;
                        end
                        default: n_state = S_WB;
                    endcase
                end
            end
            S_RD2: begin
                n_first   = ram_rdata;
                ram_raddr = AW'(r_sp - PW'(2));
                n_state   = S_OPS;
            end
            S_OPS: begin
                n_sp     = r_sp - PW'(2);
                n_neg    = ram_rdata[VB-1] ^ r_first[VB-1];
                n_ma     = ram_rdata[VB-1] ? VB'(-ram_rdata) : ram_rdata;
                n_mb     = r_first[VB-1] ? VB'(-r_first) : r_first;
                n_acc    = '0;
                n_pp     = '0;
                n_cnt    = '0;
                n_rem    = '0;
                n_quo    = NB'({(ram_rdata[VB-1] ? VB'(-ram_rdata) : ram_rdata),
                                 {FRAC_BITS{1'b0}}} );
                n_state  = S_WB;
                case (r_tok.token_char)
                    CH_ADD: begin
                        sum_w = (VB+1)'($signed(ram_rdata)) + (VB+1)'(r_first);
                        n_val = (sum_w > (VB+1)'(VMAX)) ? VMAX :
                                (sum_w < (VB+1)'(VMIN)) ? VMIN : VB'(sum_w);
                    end
                    CH_SUB: begin
                        sum_w = (VB+1)'($signed(ram_rdata)) - (VB+1)'(r_first);
                        n_val = (sum_w > (VB+1)'(VMAX)) ? VMAX :
                                (sum_w < (VB+1)'(VMIN)) ? VMIN : VB'(sum_w);
                    end
                    CH_MUL: n_state = S_MUL;
                    CH_DIV: begin
                        if (r_first == '0) n_stat = ST_DIV0;
                        else n_state = S_DIV;
                    end
                    default: n_stat = ST_BADOP;
                endcase
            end
            S_MUL: begin
                // partial product for r_pp is issued; collect next cycle
                n_state = S_MUL2;
            end
            S_MUL2: begin
                unique case (r_pp)
                    2'd0: prod_sh = (PB+2)'(pprod);
                    2'd1, 2'd2: prod_sh = (PB+2)'(pprod) << HB;
                    default: prod_sh = (PB+2)'(pprod) << (2 * HB);
                endcase
                n_acc = r_acc + prod_sh;
                if (r_pp == 2'd3) begin
                    n_val   = pack_mag(r_neg,
                                       |(n_acc >> (FRAC_BITS + VB)),
                                       VB'(n_acc >> FRAC_BITS));
                    n_state = S_WB;
                end else begin
                    n_pp    = r_pp + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                // one restoring step per cycle, dividend MSB first
                rem_sh  = {r_rem[VB-1:0], r_quo[NB-1]};
                rem_try = (VB+2)'(rem_sh) - (VB+2)'(r_mb);
                if (!rem_try[VB+1]) begin
                    n_rem = rem_try[VB:0];
                    n_quo = {r_quo[NB-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[NB-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NB - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_tok.action == ACT_END) begin
                    if (r_stat == ST_OK) n_val = ram_rdata;
                end else begin
                    n_val = pack_mag(r_neg, |(r_quo >> VB), VB'(r_quo));
                end
                n_state = S_WB;
            end
            S_WB: begin
                ram_waddr = AW'(r_sp);
                ram_wdata = r_val;
                if (r_stat != ST_OK) begin
                    n_sp = '0;
                end else if (r_tok.action == ACT_END) begin
                    n_sp = '0;
                end else if (r_tok.action == ACT_PUSH ||
                             r_tok.action == ACT_OPER) begin
                    ram_we = 1'b1;
                    n_sp   = r_sp + PW'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_out.status          = r_stat;
                n_out.result_value    = (r_stat != ST_OK) ? 32'sd0 : 32'(r_val);
                n_out.expression_done = (r_tok.action == ACT_END);
                n_out.stack_depth     = 7'(r_sp);
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
        r_tok    <= n_tok;
        r_first  <= n_first;
        r_val    <= n_val;
        r_stat   <= n_stat;
        r_neg    <= n_neg;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_acc    <= n_acc;
        r_pp     <= n_pp;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
